### rtl/core/dcp_pkg.sv
// Types and constants shared by the distance constraint projection unit.
package dcp_pkg;

  // Fixed point format of positions and lengths
  localparam int FRAC_BITS = 16;
  localparam int MinDistRound = ((2 ** FRAC_BITS) + 500) / 1000;
  localparam int MinDistInt = (MinDistRound > 0) ? MinDistRound : 1;

  // Internal widths
  localparam int MAG_W = 32;   // |second - first| per axis
  localparam int SQ_W = 64;    // square of one axis
  localparam int RAD_W = 66;   // sum of three squares
  localparam int ROOT_W = 33;  // floor square root of the sum
  localparam int SREM_W = 36;  // square root partial remainder
  localparam int SQ_STEPS = ROOT_W;
  localparam int STIFF_W = 17;
  localparam int P1_W = 49;    // magnitude times stiffness
  localparam int P1_LO_W = 24;
  localparam int DIFF_W = 33;  // |dist - rest|
  localparam int DEN_W = 50;   // dist * 2^17
  localparam int NUM_W = 82;   // numerator plus rounding term
  localparam int Q_W = 35;     // quotient bits produced
  localparam int DIV_STEPS = Q_W;
  localparam int LAT = 3 + SQ_STEPS + 3 + DIV_STEPS + 1;
  localparam int CNT_W = $clog2(LAT + 2);

  localparam logic [ROOT_W-1:0] DIST_FLOOR = ROOT_W'(MinDistInt);
  localparam logic [STIFF_W-1:0] STIFF_ONE = STIFF_W'(65536);

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        rest_len;
    logic [16:0]        spring_stiffness;
  } dcp_in_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_z;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_z;
  } dcp_out_t;

  // Saturate a 37 bit signed sum to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/distance_constraint_projection_unit.sv
// Distance constraint projection unit: pipelined spring correction of two particles.
// One constraint transaction is accepted every clock cycle while in_stall_o is low;
// its result passes through 75 register stages: 3 front stages, 33 square root
// stages, 3 product stages, 35 divider stages, 1 output stage. The square root
// resolves one root bit per stage and the three dividers one quotient bit per
// stage, so the latency is set by those two chains. The whole pipeline advances
// together: when a finished result is stalled at the output, in_stall_o is raised
// and nothing inside moves; empty slots in the pipeline are filled as soon as the
// output drains.
module distance_constraint_projection_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dcp_pkg::dcp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dcp_pkg::dcp_out_t out_data_o
);

  localparam int LAT = dcp_pkg::LAT;
  localparam int SQS = dcp_pkg::SQ_STEPS;
  localparam int DVS = dcp_pkg::DIV_STEPS;

  logic en;
  logic [LAT-1:0] vld_q, vld_d;

  // Global advance: move when the output slot is empty or being taken
  assign en = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[LAT-1];
  assign vld_d = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // ---------------- Stage 1: differences and magnitudes
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];
  logic [dcp_pkg::MAG_W-1:0] s1_mag_d [3];
  logic [2:0] s1_dneg_d;
  dcp_pkg::dcp_in_t s1_in_q;
  logic [dcp_pkg::MAG_W-1:0] s1_mag_q [3];
  logic [2:0] s1_dneg_q;

  always_comb begin
    logic signed [32:0] d;
    in_a[0] = in_data_i.first_x;
    in_a[1] = in_data_i.first_y;
    in_a[2] = in_data_i.first_z;
    in_b[0] = in_data_i.second_x;
    in_b[1] = in_data_i.second_y;
    in_b[2] = in_data_i.second_z;
    for (int k = 0; k < 3; k++) begin
      d = 33'(in_b[k]) - 33'(in_a[k]);
      s1_dneg_d[k] = d[32];
      s1_mag_d[k] = d[32] ? 32'(-d) : d[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_in_q <= in_data_i;
      s1_mag_q <= s1_mag_d;
      s1_dneg_q <= s1_dneg_d;
    end
  end

  // ---------------- Stage 2: squares and magnitude times stiffness
  logic [dcp_pkg::STIFF_W-1:0] s2_stiff;
  dcp_pkg::dcp_in_t s2_in_q;
  logic [2:0] s2_dneg_q;
  logic [dcp_pkg::SQ_W-1:0] s2_sq_q [3];
  logic [dcp_pkg::P1_W-1:0] s2_p1_q [3];

  assign s2_stiff = (s1_in_q.spring_stiffness > dcp_pkg::STIFF_ONE) ?
                    dcp_pkg::STIFF_ONE : s1_in_q.spring_stiffness;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_in_q <= s1_in_q;
      s2_dneg_q <= s1_dneg_q;
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= dcp_pkg::SQ_W'(s1_mag_q[k]) * dcp_pkg::SQ_W'(s1_mag_q[k]);
        s2_p1_q[k] <= dcp_pkg::P1_W'(s1_mag_q[k]) * dcp_pkg::P1_W'(s2_stiff);
      end
    end
  end

  // ---------------- Stage 3: sum of squares
  dcp_pkg::dcp_in_t s3_in_q;
  logic [2:0] s3_dneg_q;
  logic [dcp_pkg::P1_W-1:0] s3_p1_q [3];
  logic [dcp_pkg::RAD_W-1:0] s3_rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_in_q <= s2_in_q;
      s3_dneg_q <= s2_dneg_q;
      s3_p1_q <= s2_p1_q;
      s3_rad_q <= dcp_pkg::RAD_W'(s2_sq_q[0]) + dcp_pkg::RAD_W'(s2_sq_q[1])
                + dcp_pkg::RAD_W'(s2_sq_q[2]);
    end
  end

  // ---------------- Square root: one root bit per stage, most significant first
  dcp_pkg::dcp_in_t sq_in_q [SQS];
  logic [2:0] sq_dneg_q [SQS];
  logic [dcp_pkg::P1_W-1:0] sq_p1_q [SQS][3];
  logic [dcp_pkg::RAD_W-1:0] sq_rad_q [SQS];
  logic [dcp_pkg::SREM_W-1:0] sq_rem_q [SQS];
  logic [dcp_pkg::SREM_W-1:0] sq_rem_d [SQS];
  logic [dcp_pkg::ROOT_W-1:0] sq_root_q [SQS];
  logic [dcp_pkg::ROOT_W-1:0] sq_root_d [SQS];

  always_comb begin
    logic [dcp_pkg::SREM_W-1:0] rem_in, trial, rem_t;
    logic [dcp_pkg::ROOT_W-1:0] root_in;
    logic [dcp_pkg::RAD_W-1:0] rad_in;
    for (int j = 0; j < SQS; j++) begin
      if (j == 0) begin
        rem_in = '0;
        root_in = '0;
        rad_in = s3_rad_q;
      end else begin
        rem_in = sq_rem_q[j-1];
        root_in = sq_root_q[j-1];
        rad_in = sq_rad_q[j-1];
      end
      rem_t = {rem_in[dcp_pkg::SREM_W-3:0], rad_in[2*(SQS-1-j) +: 2]};
      trial = dcp_pkg::SREM_W'({root_in, 2'b01});
      if (rem_t >= trial) begin
        sq_rem_d[j] = rem_t - trial;
        sq_root_d[j] = {root_in[dcp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_d[j] = rem_t;
        sq_root_d[j] = {root_in[dcp_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < SQS; j++) begin
        if (j == 0) begin
          sq_in_q[j] <= s3_in_q;
          sq_dneg_q[j] <= s3_dneg_q;
          sq_p1_q[j] <= s3_p1_q;
          sq_rad_q[j] <= s3_rad_q;
        end else begin
          sq_in_q[j] <= sq_in_q[j-1];
          sq_dneg_q[j] <= sq_dneg_q[j-1];
          sq_p1_q[j] <= sq_p1_q[j-1];
          sq_rad_q[j] <= sq_rad_q[j-1];
        end
        sq_rem_q[j] <= sq_rem_d[j];
        sq_root_q[j] <= sq_root_d[j];
      end
    end
  end

  // ---------------- D1: clamp distance, length error and denominator
  logic [dcp_pkg::ROOT_W-1:0] d1_dist;
  logic signed [dcp_pkg::DIFF_W:0] d1_diff;
  dcp_pkg::dcp_in_t d1_in_q;
  logic [2:0] d1_neg_q;
  logic [dcp_pkg::P1_W-1:0] d1_p1_q [3];
  logic [dcp_pkg::DIFF_W-1:0] d1_diff_q;
  logic [dcp_pkg::DEN_W-1:0] d1_den_q;

  assign d1_dist = (sq_root_q[SQS-1] < dcp_pkg::DIST_FLOOR) ? dcp_pkg::DIST_FLOOR :
                   sq_root_q[SQS-1];
  assign d1_diff = $signed({1'b0, d1_dist}) -
                   $signed((dcp_pkg::DIFF_W+1)'(sq_in_q[SQS-1].rest_len));

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_in_q <= sq_in_q[SQS-1];
      d1_neg_q <= sq_dneg_q[SQS-1] ^ {3{d1_diff[dcp_pkg::DIFF_W]}};
      d1_p1_q <= sq_p1_q[SQS-1];
      d1_diff_q <= d1_diff[dcp_pkg::DIFF_W] ? dcp_pkg::DIFF_W'(-d1_diff) :
                   d1_diff[dcp_pkg::DIFF_W-1:0];
      d1_den_q <= {d1_dist, 17'd0};
    end
  end

  // ---------------- D2: partial products of the numerator
  localparam int PH_W = dcp_pkg::P1_W - dcp_pkg::P1_LO_W;
  dcp_pkg::dcp_in_t d2_in_q;
  logic [2:0] d2_neg_q;
  logic [dcp_pkg::DEN_W-1:0] d2_den_q;
  logic [dcp_pkg::P1_LO_W+dcp_pkg::DIFF_W-1:0] d2_pl_q [3];
  logic [PH_W+dcp_pkg::DIFF_W-1:0] d2_ph_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_in_q <= d1_in_q;
      d2_neg_q <= d1_neg_q;
      d2_den_q <= d1_den_q;
      for (int k = 0; k < 3; k++) begin
        d2_pl_q[k] <= (dcp_pkg::P1_LO_W+dcp_pkg::DIFF_W)'(d1_p1_q[k][dcp_pkg::P1_LO_W-1:0])
                    * (dcp_pkg::P1_LO_W+dcp_pkg::DIFF_W)'(d1_diff_q);
        d2_ph_q[k] <= (PH_W+dcp_pkg::DIFF_W)'(d1_p1_q[k][dcp_pkg::P1_W-1:dcp_pkg::P1_LO_W])
                    * (PH_W+dcp_pkg::DIFF_W)'(d1_diff_q);
      end
    end
  end

  // ---------------- D3: numerator with rounding term
  dcp_pkg::dcp_in_t d3_in_q;
  logic [2:0] d3_neg_q;
  logic [dcp_pkg::DEN_W-1:0] d3_den_q;
  logic [dcp_pkg::NUM_W-1:0] d3_num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_in_q <= d2_in_q;
      d3_neg_q <= d2_neg_q;
      d3_den_q <= d2_den_q;
      for (int k = 0; k < 3; k++) begin
        d3_num_q[k] <= (dcp_pkg::NUM_W'(d2_ph_q[k]) << dcp_pkg::P1_LO_W)
                     + dcp_pkg::NUM_W'(d2_pl_q[k])
                     + dcp_pkg::NUM_W'(d2_den_q[dcp_pkg::DEN_W-1:1]);
      end
    end
  end

  // ---------------- Divider: one quotient bit per stage for each axis
  dcp_pkg::dcp_in_t dv_in_q [DVS];
  logic [2:0] dv_neg_q [DVS];
  logic [dcp_pkg::DEN_W-1:0] dv_den_q [DVS];
  logic [dcp_pkg::Q_W-1:0] dv_low_q [DVS][3];
  logic [dcp_pkg::DEN_W-1:0] dv_rem_q [DVS][3];
  logic [dcp_pkg::DEN_W-1:0] dv_rem_d [DVS][3];
  logic [dcp_pkg::Q_W-1:0] dv_quo_q [DVS][3];
  logic [dcp_pkg::Q_W-1:0] dv_quo_d [DVS][3];

  always_comb begin
    logic [dcp_pkg::DEN_W:0] t;
    logic [dcp_pkg::DEN_W-1:0] rem_in, den_in;
    logic [dcp_pkg::Q_W-1:0] quo_in, low_in;
    for (int j = 0; j < DVS; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (j == 0) begin
          rem_in = dcp_pkg::DEN_W'(d3_num_q[k][dcp_pkg::NUM_W-1:dcp_pkg::Q_W]);
          low_in = d3_num_q[k][dcp_pkg::Q_W-1:0];
          quo_in = '0;
          den_in = d3_den_q;
        end else begin
          rem_in = dv_rem_q[j-1][k];
          low_in = dv_low_q[j-1][k];
          quo_in = dv_quo_q[j-1][k];
          den_in = dv_den_q[j-1];
        end
        t = {rem_in, low_in[DVS-1-j]};
        if (t >= {1'b0, den_in}) begin
          dv_rem_d[j][k] = dcp_pkg::DEN_W'(t - {1'b0, den_in});
          dv_quo_d[j][k] = {quo_in[dcp_pkg::Q_W-2:0], 1'b1};
        end else begin
          dv_rem_d[j][k] = t[dcp_pkg::DEN_W-1:0];
          dv_quo_d[j][k] = {quo_in[dcp_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DVS; j++) begin
        if (j == 0) begin
          dv_in_q[j] <= d3_in_q;
          dv_neg_q[j] <= d3_neg_q;
          dv_den_q[j] <= d3_den_q;
          for (int k = 0; k < 3; k++) begin
            dv_low_q[j][k] <= d3_num_q[k][dcp_pkg::Q_W-1:0];
          end
        end else begin
          dv_in_q[j] <= dv_in_q[j-1];
          dv_neg_q[j] <= dv_neg_q[j-1];
          dv_den_q[j] <= dv_den_q[j-1];
          dv_low_q[j] <= dv_low_q[j-1];
        end
        dv_rem_q[j] <= dv_rem_d[j];
        dv_quo_q[j] <= dv_quo_d[j];
      end
    end
  end

  // ---------------- Output stage: apply signed correction and saturate
  dcp_pkg::dcp_in_t fin;
  logic signed [31:0] fa [3];
  logic signed [31:0] fb [3];
  logic signed [dcp_pkg::Q_W:0] corr [3];
  logic signed [31:0] res_a [3];
  logic signed [31:0] res_b [3];
  dcp_pkg::dcp_out_t out_d;
  dcp_pkg::dcp_out_t out_q;

  assign fin = dv_in_q[DVS-1];

  always_comb begin
    fa[0] = fin.first_x;
    fa[1] = fin.first_y;
    fa[2] = fin.first_z;
    fb[0] = fin.second_x;
    fb[1] = fin.second_y;
    fb[2] = fin.second_z;
    for (int k = 0; k < 3; k++) begin
      corr[k] = dv_neg_q[DVS-1][k] ? -$signed({1'b0, dv_quo_q[DVS-1][k]}) :
                                     $signed({1'b0, dv_quo_q[DVS-1][k]});
      res_a[k] = dcp_pkg::sat32(37'(fa[k]) + 37'(corr[k]));
      res_b[k] = dcp_pkg::sat32(37'(fb[k]) - 37'(corr[k]));
    end
    out_d.new_first_x = res_a[0];
    out_d.new_first_y = res_a[1];
    out_d.new_first_z = res_a[2];
    out_d.new_second_x = res_b[0];
    out_d.new_second_y = res_b[1];
    out_d.new_second_z = res_b[2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/dcp_checker.sv
// Port level checks for the distance constraint projection unit, bound to the top level.
module dcp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dcp_pkg::dcp_out_t out_data_o
);

  logic [dcp_pkg::CNT_W-1:0] inflight_q;
  logic in_acc, out_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0) else $error("result without a transaction");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("input taken while pipeline frozen");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= dcp_pkg::CNT_W'(dcp_pkg::LAT)) else $error("too many transactions in flight");

endmodule

bind distance_constraint_projection_unit dcp_checker u_dcp_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o(out_data_o)
);
